// File: src/ftc_pkg.sv
// Shared types, constants and helper functions of the flow table counter.
`timescale 1ns / 1ps
package ftc_pkg;

  localparam int TABLE_BUCKETS_DEF = 256;
  localparam int BUCKET_WAYS_DEF   = 10;
  localparam int WAY_W             = 4;
  localparam int BKT_MAX_W         = 16;
  localparam int TOTAL_W           = 12;
  localparam int CNT_W             = 64;
  localparam int KEY_W             = 296;
  localparam int CRC_BYTES         = 16;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic KIND_CLEAR      = 1'b1;

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_CREATED = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] src_ip_hi;
    logic [63:0] src_ip_lo;
    logic [63:0] dst_ip_hi;
    logic [63:0] dst_ip_lo;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic [15:0] len_bytes;
  } ftc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hash_value;
    logic [7:0]  bucket_index;
    logic [3:0]  slot;
    logic [63:0] flow_packets;
    logic [63:0] flow_bytes;
    logic [11:0] total_flows;
  } ftc_out_t;

  // Request handed from the hash front end to the table back end.
  typedef struct packed {
    ftc_in_t                pkt;
    logic [31:0]            hash;
    logic [BKT_MAX_W-1:0]   bucket;
  } ftc_req_t;

  typedef enum logic [2:0] {
    F_IDLE, F_CRC, F_SUM, F_MOD, F_REM, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_FILL, B_SCAN_RD, B_SCAN_CMP, B_DECIDE, B_CNT, B_RESP
  } back_state_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [KEY_W-1:0] key_of(input ftc_in_t p);
    return {p.src_ip_hi, p.src_ip_lo, p.dst_ip_hi, p.dst_ip_lo,
            p.sport, p.dport, p.protocol};
  endfunction

endpackage

// File: src/ftc_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface ftc_in_if import ftc_pkg::*; ();
  logic    valid;
  logic    ready;
  ftc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ftc_out_if import ftc_pkg::*; ();
  logic     valid;
  logic     ready;
  ftc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ftc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ftc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ftc_front.sv
// Front end: accepts requests, computes the tuple hash and bucket.
`timescale 1ns / 1ps
module ftc_front import ftc_pkg::*; #(
  parameter int TABLE_BUCKETS = TABLE_BUCKETS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ftc_in_if.sink   in_ch,
  output ftc_req_t push_data,
  output logic     push_valid,
  input  logic     push_ready
);

  localparam int BKT_W  = (TABLE_BUCKETS > 1) ? $clog2(TABLE_BUCKETS) : 1;
  // Reciprocal for hash mod TABLE_BUCKETS: exact for every 32-bit hash.
  localparam int MOD_SH = 32 + $clog2(TABLE_BUCKETS);
  localparam logic [32:0] RECIP = 33'(((65'd1 << MOD_SH) + 65'(TABLE_BUCKETS) - 65'd1)
                                      / 65'(TABLE_BUCKETS));
  localparam logic [BKT_W-1:0] MODV = BKT_W'(TABLE_BUCKETS);

  front_state_t       state_r, state_nxt;
  ftc_in_t            pkt_r, pkt_nxt;
  logic [127:0]       ord_r, ord_nxt;
  logic [31:0]        c1_r, c1_nxt, c2_r, c2_nxt, c3_r, c3_nxt;
  logic [31:0]        hash_r, hash_nxt;
  logic [64:0]        prod_r, prod_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [BKT_W-1:0]   rem_r, rem_nxt;
  logic [127:0]       addr_or, addr_ord;
  logic [15:0]        ports_or;
  logic [64:0]        quo;

  assign addr_or  = {in_ch.data.src_ip_hi | in_ch.data.dst_ip_hi,
                     in_ch.data.src_ip_lo | in_ch.data.dst_ip_lo};
  assign ports_or = pkt_r.sport | pkt_r.dport;
  assign quo      = prod_r >> MOD_SH;

  // Word 0 first, each word least significant byte first.
  always_comb begin
    for (int k = 0; k < CRC_BYTES; k++) begin
      addr_ord[8*k +: 8] = addr_or[(3 - k/4)*32 + (k%4)*8 +: 8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    pkt_nxt   = pkt_r;
    ord_nxt   = ord_r;
    c1_nxt    = c1_r;
    c2_nxt    = c2_r;
    c3_nxt    = c3_r;
    hash_nxt  = hash_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          pkt_nxt  = in_ch.data;
          ord_nxt  = addr_ord;
          c1_nxt   = CRC_INIT;
          c2_nxt   = CRC_INIT;
          c3_nxt   = CRC_INIT;
          cnt_nxt  = '0;
          hash_nxt = '0;
          rem_nxt  = '0;
          state_nxt = (in_ch.data.kind == KIND_CLEAR) ? F_PUSH : F_CRC;
        end
      end
      F_CRC: begin
        c1_nxt  = crc_byte(c1_r, ord_r[7:0]);
        ord_nxt = ord_r >> 8;
        if (cnt_r == 4'd0) begin
          c2_nxt = crc_byte(c2_r, ports_or[7:0]);
          c3_nxt = crc_byte(c3_r, pkt_r.protocol);
        end else if (cnt_r == 4'd1) begin
          c2_nxt = crc_byte(c2_r, ports_or[15:8]);
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(CRC_BYTES - 1)) begin
          state_nxt = F_SUM;
        end
      end
      F_SUM: begin
        hash_nxt  = ~c1_r + ~c2_r + ~c3_r;
        state_nxt = F_MOD;
      end
      F_MOD: begin
        // quotient estimate by reciprocal multiply
        prod_nxt  = 65'(hash_r) * 65'(RECIP);
        state_nxt = F_REM;
      end
      F_REM: begin
        // remainder needs only the low bucket bits
        rem_nxt   = hash_r[BKT_W-1:0] - quo[BKT_W-1:0] * MODV;
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pkt_r  <= pkt_nxt;
    ord_r  <= ord_nxt;
    c1_r   <= c1_nxt;
    c2_r   <= c2_nxt;
    c3_r   <= c3_nxt;
    hash_r <= hash_nxt;
    prod_r <= prod_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
  end

  assign in_ch.ready      = (state_r == F_IDLE);
  assign push_valid       = (state_r == F_PUSH);
  assign push_data.pkt    = pkt_r;
  assign push_data.hash   = hash_r;
  assign push_data.bucket = BKT_MAX_W'(rem_r);

endmodule

// File: src/ftc_queue.sv
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps
module ftc_queue import ftc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ftc_req_t push_data,
  input  logic     push_valid,
  output logic     push_ready,
  output ftc_req_t pop_data,
  output logic     pop_valid,
  input  logic     pop_ready
);

  ftc_req_t   mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// File: src/ftc_back.sv
// Back end: table clear, bucket scan, flow insert and counter update, result register.
`timescale 1ns / 1ps
module ftc_back import ftc_pkg::*; #(
  parameter int TABLE_BUCKETS = TABLE_BUCKETS_DEF,
  parameter int BUCKET_WAYS   = BUCKET_WAYS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ftc_req_t pop_data,
  input  logic     pop_valid,
  output logic     pop_ready,
  ftc_out_if.source out_ch
);

  localparam int BKT_W  = (TABLE_BUCKETS > 1) ? $clog2(TABLE_BUCKETS) : 1;
  localparam int SLOT_N = TABLE_BUCKETS * BUCKET_WAYS;
  localparam int SLOT_W = (SLOT_N > 1) ? $clog2(SLOT_N) : 1;
  localparam logic [WAY_W-1:0] WAYS = WAY_W'(BUCKET_WAYS);

  back_state_t              state_r, state_nxt;
  ftc_req_t                 req_r, req_nxt;
  logic [WAY_W-1:0]         fill_r, fill_nxt, idx_r, idx_nxt, hit_r, hit_nxt;
  logic                     found_r, found_nxt;
  logic [SLOT_W-1:0]        base_r, base_nxt;
  logic [TABLE_BUCKETS-1:0] vld_r, vld_nxt;
  logic [TOTAL_W-1:0]       total_r, total_nxt;
  ftc_out_t                 pend_r, pend_nxt, out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [BKT_W-1:0]  bkt, q_bkt;
  logic [WAY_W-1:0]  fill_rd, fill_clip;
  logic [KEY_W-1:0]  key_rd;
  logic [127:0]      cnt_rd, cnt_wdata;
  logic [SLOT_W-1:0] key_raddr, cnt_raddr, slot_waddr;
  logic              key_we, cnt_we, fill_we;
  logic [63:0]       pk_new, by_new;

  assign bkt        = req_r.bucket[BKT_W-1:0];
  assign q_bkt      = pop_data.bucket[BKT_W-1:0];
  assign key_raddr  = base_r + SLOT_W'(idx_r);
  assign cnt_raddr  = base_r + SLOT_W'(hit_r);
  assign slot_waddr = found_r ? cnt_raddr : base_r + SLOT_W'(fill_r);
  assign pk_new     = cnt_rd[127:64] + 64'd1;
  assign by_new     = cnt_rd[63:0] + 64'(req_r.pkt.len_bytes);

  ftc_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_N)) u_key_ram (
    .clk, .we(key_we), .waddr(slot_waddr), .wdata(key_of(req_r.pkt)),
    .raddr(key_raddr), .rdata(key_rd)
  );

  ftc_ram #(.WIDTH(128), .DEPTH(SLOT_N)) u_cnt_ram (
    .clk, .we(cnt_we), .waddr(slot_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rd)
  );

  ftc_ram #(.WIDTH(WAY_W), .DEPTH(TABLE_BUCKETS)) u_fill_ram (
    .clk, .we(fill_we), .waddr(bkt), .wdata(fill_r + WAY_W'(1)),
    .raddr(q_bkt), .rdata(fill_rd)
  );

  always_comb begin
    fill_clip = vld_r[bkt] ? fill_rd : '0;
    if (fill_clip > WAYS) begin
      fill_clip = WAYS;
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    found_nxt = found_r;
    base_nxt  = base_r;
    vld_nxt   = vld_r;
    total_nxt = total_r;
    pend_nxt  = pend_r;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    fill_we   = 1'b0;
    cnt_wdata = {pk_new, by_new};
    pop_ready = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt   = out_r;
    unique case (state_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          req_nxt = pop_data;
          if (pop_data.pkt.kind == KIND_CLEAR) begin
            vld_nxt   = '0;
            total_nxt = '0;
            pend_nxt  = '0;
            pend_nxt.status = ST_CLEARED;
            state_nxt = B_RESP;
          end else begin
            state_nxt = B_FILL;
          end
        end
      end
      B_FILL: begin
        fill_nxt  = fill_clip;
        base_nxt  = SLOT_W'(bkt) * SLOT_W'(BUCKET_WAYS);
        idx_nxt   = '0;
        hit_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = (fill_clip == '0) ? B_DECIDE : B_SCAN_RD;
      end
      B_SCAN_RD: begin
        state_nxt = B_SCAN_CMP;
      end
      B_SCAN_CMP: begin
        if (key_rd == key_of(req_r.pkt)) begin
          found_nxt = 1'b1;
          hit_nxt   = idx_r;
        end
        idx_nxt   = idx_r + WAY_W'(1);
        state_nxt = (idx_nxt == fill_r) ? B_DECIDE : B_SCAN_RD;
      end
      B_DECIDE: begin
        pend_nxt.hash_value   = req_r.hash;
        pend_nxt.bucket_index = req_r.bucket[7:0];
        if (found_r) begin
          state_nxt = B_CNT;
        end else if (fill_r < WAYS) begin
          key_we    = 1'b1;
          cnt_we    = 1'b1;
          fill_we   = 1'b1;
          cnt_wdata = {64'd1, 64'(req_r.pkt.len_bytes)};
          vld_nxt[bkt] = 1'b1;
          total_nxt = total_r + TOTAL_W'(1);
          pend_nxt.status       = ST_CREATED;
          pend_nxt.slot         = fill_r;
          pend_nxt.flow_packets = 64'd1;
          pend_nxt.flow_bytes   = 64'(req_r.pkt.len_bytes);
          pend_nxt.total_flows  = total_r + TOTAL_W'(1);
          state_nxt = B_RESP;
        end else begin
          pend_nxt.status       = ST_FULL;
          pend_nxt.slot         = '0;
          pend_nxt.flow_packets = '0;
          pend_nxt.flow_bytes   = '0;
          pend_nxt.total_flows  = total_r;
          state_nxt = B_RESP;
        end
      end
      B_CNT: begin
        cnt_we = 1'b1;
        pend_nxt.status       = ST_UPDATED;
        pend_nxt.slot         = hit_r;
        pend_nxt.flow_packets = pk_new;
        pend_nxt.flow_bytes   = by_new;
        pend_nxt.total_flows  = total_r;
        state_nxt = B_RESP;
      end
      B_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      vld_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r   <= req_nxt;
    fill_r  <= fill_nxt;
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    found_r <= found_nxt;
    base_r  <= base_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

// File: src/flow_table_tuple_counter_unit.sv
// Top level of the hashed 5-tuple flow table counter.
`timescale 1ns / 1ps
// Counts packets and bytes per flow in a table of TABLE_BUCKETS buckets with
// up to BUCKET_WAYS flows each. The front end takes one request, hashes the
// ORed addresses, ports and protocol with CRC-32 one byte per cycle, sums
// the three CRCs, then reduces modulo TABLE_BUCKETS by a reciprocal multiply
// and a low-bit subtract, and pushes; it takes a new request only after the push.
// A two-entry queue lets the back end run behind it: it takes the request
// and reads the bucket fill, reads and compares each stored way in turn,
// then inserts, or updates the counters of the matching way, and hands the
// result to the output register. The slower of the two sides sets the
// sustained rate; a stalled output holds the back end, then the queue, then
// the input. A clear request empties the table at once (per-bucket valid
// bits); no clearing pass is needed after reset. Every request gives one
// result.
module flow_table_tuple_counter_unit import ftc_pkg::*; #(
  parameter int TABLE_BUCKETS = TABLE_BUCKETS_DEF,
  parameter int BUCKET_WAYS   = BUCKET_WAYS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ftc_in_if.sink    in_ch,
  ftc_out_if.source out_ch
);

  ftc_req_t push_data, pop_data;
  logic     push_valid, push_ready, pop_valid, pop_ready;

  // hash and bucket
  ftc_front #(.TABLE_BUCKETS(TABLE_BUCKETS)) u_front (
    .clk, .rst_n, .in_ch,
    .push_data, .push_valid, .push_ready
  );

  // decouples hashing from table access
  ftc_queue u_queue (
    .clk, .rst_n,
    .push_data, .push_valid, .push_ready,
    .pop_data, .pop_valid, .pop_ready
  );

  // table lookup, insert, counter update
  ftc_back #(.TABLE_BUCKETS(TABLE_BUCKETS), .BUCKET_WAYS(BUCKET_WAYS)) u_back (
    .clk, .rst_n,
    .pop_data, .pop_valid, .pop_ready,
    .out_ch
  );

endmodule
